@@ hw/rtl/pcpa_pkg.sv @@
// Shared constants, types and codes for the per-CPU page allocator.
package pcpa_pkg;

  localparam int CPUS       = 8;
  localparam int CPU_W      = $clog2(CPUS);
  localparam int VIC_W      = CPU_W + 1;
  localparam int PAGES      = 32768;
  localparam int PG_W       = $clog2(PAGES);
  localparam int HEAD_W     = PG_W + 1;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 32;
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int FP_W       = PFN_W + 1;
  localparam int BATCH_W    = 13;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 4;
  localparam int REG_IDX_W  = PADDR_W - 2;

  localparam logic [HEAD_W-1:0] NULL_IDX = HEAD_W'(PAGES);

  localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0]  TOP_RESET   = 32'h8800_0000;
  localparam logic [BATCH_W-1:0] BATCH_RESET = 13'd64;

  localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BATCH = 2'd2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_PUSH,
    S_ALLOC,
    S_STEAL,
    S_STEAL_MV,
    S_POP_RD,
    S_POP_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  top;
    logic [BATCH_W-1:0] batch;
  } cfg_t;

endpackage

@@ hw/rtl/pcpa_if.sv @@
// Request and response channel interfaces of the page allocator.
interface pcpa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [pcpa_pkg::CPU_W-1:0]     cpu;
  logic [pcpa_pkg::ADDR_W-1:0]    address;

  modport source(output valid, cmd, cpu, address, input ready);
  modport sink(input valid, cmd, cpu, address, output ready);
endinterface

interface pcpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pcpa_pkg::ADDR_W-1:0]    page_address;
  logic [1:0]                     status;

  modport source(output valid, page_address, status, input ready);
  modport sink(input valid, page_address, status, output ready);
endinterface

@@ hw/rtl/pcpa_regs.sv @@
// APB configuration registers of the page allocator.
module pcpa_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [pcpa_pkg::DATA_W-1:0]    pwdata,
  output logic [pcpa_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output pcpa_pkg::cfg_t                 cfg
);

  logic                              wr;
  logic [pcpa_pkg::REG_IDX_W-1:0]    idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[pcpa_pkg::PADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base  <= pcpa_pkg::BASE_RESET;
      cfg.top   <= pcpa_pkg::TOP_RESET;
      cfg.batch <= pcpa_pkg::BATCH_RESET;
    end else if (wr) begin
      unique case (idx)
        pcpa_pkg::REG_BASE:  cfg.base  <= pwdata;
        pcpa_pkg::REG_TOP:   cfg.top   <= pwdata;
        pcpa_pkg::REG_BATCH: cfg.batch <= pwdata[pcpa_pkg::BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pcpa_pkg::REG_BASE:  prdata = cfg.base;
      pcpa_pkg::REG_TOP:   prdata = cfg.top;
      pcpa_pkg::REG_BATCH: prdata = pcpa_pkg::DATA_W'(cfg.batch);
      default:             prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/per_cpu_page_allocator_with_stealing_unit.sv @@
// Top level of the per-CPU page allocator: sequencer, list heads and link memory.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, cpu, address
//   rsp      out  valid/ready    page_address, status
//   apb      in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// A free passes the free and push states before the response state, an allocate from
// a non-empty list the alloc, pop-read and pop-write states. An empty list adds a steal
// and a move state per stolen page and a steal state per CPU passed over; OOM skips pop-write.
// rst clears the list heads, sequencer and configuration; the link memory
// is not cleared. req.ready is high only when idle; a stalled result holds the
// sequencer in its response state while the previous result is still held.
module per_cpu_page_allocator_with_stealing_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [pcpa_pkg::DATA_W-1:0]    pwdata,
  output logic [pcpa_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  pcpa_req_if.sink                       req,
  pcpa_rsp_if.source                     rsp
);

  pcpa_pkg::cfg_t    cfg;
  pcpa_pkg::state_t  state, state_next;

  logic [pcpa_pkg::HEAD_W-1:0]  head [pcpa_pkg::CPUS];
  logic [pcpa_pkg::HEAD_W-1:0]  link_mem [pcpa_pkg::PAGES];

  logic [pcpa_pkg::CPU_W-1:0]   cpu;
  logic [pcpa_pkg::ADDR_W-1:0]  address;
  logic [pcpa_pkg::HEAD_W-1:0]  cur_head;
  logic [pcpa_pkg::HEAD_W-1:0]  vic;
  logic [pcpa_pkg::VIC_W-1:0]   victim;
  logic [pcpa_pkg::BATCH_W-1:0] left;
  logic                         range_bad;
  logic [pcpa_pkg::FP_W-1:0]    pg_diff;
  logic [pcpa_pkg::ADDR_W-1:0]  res_addr;
  pcpa_pkg::status_t            res_status;

  logic [pcpa_pkg::FP_W-1:0]    fp;
  logic [pcpa_pkg::FP_W-1:0]    alloc_pfn;
  logic                         pg_oob;
  logic                         victim_end;
  logic                         skip_victim;
  logic                         resp_free;

  logic [pcpa_pkg::CPU_W-1:0]   head_rsel;
  logic [pcpa_pkg::HEAD_W-1:0]  head_rdata;
  logic                         head_we;
  logic [pcpa_pkg::CPU_W-1:0]   head_wsel;
  logic [pcpa_pkg::HEAD_W-1:0]  head_wdata;
  logic [pcpa_pkg::PG_W-1:0]    mem_raddr;
  logic [pcpa_pkg::HEAD_W-1:0]  mem_rdata;
  logic                         mem_we;
  logic [pcpa_pkg::PG_W-1:0]    mem_waddr;
  logic [pcpa_pkg::HEAD_W-1:0]  mem_wdata;

  pcpa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign fp = pcpa_pkg::FP_W'(cfg.base[pcpa_pkg::ADDR_W-1:pcpa_pkg::PAGE_SHIFT])
            + pcpa_pkg::FP_W'(|cfg.base[pcpa_pkg::PAGE_SHIFT-1:0]);
  assign alloc_pfn   = fp + pcpa_pkg::FP_W'(cur_head);
  assign pg_oob      = pg_diff >= pcpa_pkg::FP_W'(pcpa_pkg::PAGES);
  assign victim_end  = (left == '0) || (victim == pcpa_pkg::VIC_W'(pcpa_pkg::CPUS));
  assign skip_victim = (victim[pcpa_pkg::CPU_W-1:0] == cpu) || (head_rdata == pcpa_pkg::NULL_IDX);
  assign resp_free   = !rsp.valid || rsp.ready;
  assign head_rdata  = head[head_rsel];
  assign req.ready   = (state == pcpa_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      pcpa_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = (req.cmd == pcpa_pkg::CMD_FREE) ? pcpa_pkg::S_FREE : pcpa_pkg::S_ALLOC;
        end
      end
      pcpa_pkg::S_FREE:  state_next = pcpa_pkg::S_PUSH;
      pcpa_pkg::S_PUSH:  state_next = pcpa_pkg::S_RESP;
      pcpa_pkg::S_ALLOC: begin
        state_next = (cur_head == pcpa_pkg::NULL_IDX) ? pcpa_pkg::S_STEAL : pcpa_pkg::S_POP_RD;
      end
      pcpa_pkg::S_STEAL: begin
        priority if (victim_end) begin
          state_next = pcpa_pkg::S_POP_RD;
        end else if (!skip_victim) begin
          state_next = pcpa_pkg::S_STEAL_MV;
        end
      end
      pcpa_pkg::S_STEAL_MV: state_next = pcpa_pkg::S_STEAL;
      pcpa_pkg::S_POP_RD: begin
        state_next = (cur_head == pcpa_pkg::NULL_IDX) ? pcpa_pkg::S_RESP : pcpa_pkg::S_POP_WR;
      end
      pcpa_pkg::S_POP_WR: state_next = pcpa_pkg::S_RESP;
      pcpa_pkg::S_RESP: begin
        if (resp_free) begin
          state_next = pcpa_pkg::S_IDLE;
        end
      end
      default: state_next = pcpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_rsel  = cpu;
    head_we    = 1'b0;
    head_wsel  = cpu;
    head_wdata = mem_rdata;
    mem_raddr  = cur_head[pcpa_pkg::PG_W-1:0];
    mem_we     = 1'b0;
    mem_waddr  = pg_diff[pcpa_pkg::PG_W-1:0];
    mem_wdata  = cur_head;
    unique case (state)
      pcpa_pkg::S_IDLE: head_rsel = req.cpu;
      pcpa_pkg::S_PUSH: begin
        head_we    = !range_bad && !pg_oob;
        head_wdata = pcpa_pkg::HEAD_W'(pg_diff[pcpa_pkg::PG_W-1:0]);
        mem_we     = !range_bad && !pg_oob;
      end
      pcpa_pkg::S_STEAL: begin
        head_rsel = victim[pcpa_pkg::CPU_W-1:0];
        mem_raddr = head_rdata[pcpa_pkg::PG_W-1:0];
      end
      pcpa_pkg::S_STEAL_MV: begin
        head_we   = 1'b1;
        head_wsel = victim[pcpa_pkg::CPU_W-1:0];
        mem_we    = 1'b1;
        mem_waddr = vic[pcpa_pkg::PG_W-1:0];
      end
      pcpa_pkg::S_POP_WR: head_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcpa_pkg::S_IDLE;
      for (int i = 0; i < pcpa_pkg::CPUS; i++) begin
        head[i] <= pcpa_pkg::NULL_IDX;
      end
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (head_we) begin
        head[head_wsel] <= head_wdata;
      end
      if (state == pcpa_pkg::S_RESP && resp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= link_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pcpa_pkg::S_IDLE: begin
        cpu      <= req.cpu;
        address  <= req.address;
        cur_head <= head_rdata;
        left     <= cfg.batch;
        victim   <= '0;
      end
      pcpa_pkg::S_FREE: begin
        range_bad <= (address[pcpa_pkg::PAGE_SHIFT-1:0] != '0) || (address < cfg.base)
                  || (address >= cfg.top);
        pg_diff   <= pcpa_pkg::FP_W'(address[pcpa_pkg::ADDR_W-1:pcpa_pkg::PAGE_SHIFT]) - fp;
      end
      pcpa_pkg::S_PUSH: begin
        res_addr   <= '0;
        res_status <= (range_bad || pg_oob) ? pcpa_pkg::ST_BAD : pcpa_pkg::ST_OK;
      end
      pcpa_pkg::S_STEAL: begin
        if (!victim_end) begin
          if (skip_victim) begin
            victim <= victim + pcpa_pkg::VIC_W'(1);
          end else begin
            vic <= head_rdata;
          end
        end
      end
      pcpa_pkg::S_STEAL_MV: begin
        cur_head <= vic;
        left     <= left - pcpa_pkg::BATCH_W'(1);
      end
      pcpa_pkg::S_POP_RD: begin
        res_addr   <= '0;
        res_status <= pcpa_pkg::ST_OOM;
      end
      pcpa_pkg::S_POP_WR: begin
        res_addr   <= {alloc_pfn[pcpa_pkg::PFN_W-1:0], pcpa_pkg::PAGE_SHIFT'(0)};
        res_status <= pcpa_pkg::ST_OK;
      end
      pcpa_pkg::S_RESP: begin
        if (resp_free) begin
          rsp.page_address <= res_addr;
          rsp.status       <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the per-CPU page allocator with stealing.
`timescale 1ns / 1ps

module testbench;
  import pcpa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } alloc_rsp_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  pcpa_req_if req_if ();
  pcpa_rsp_if rsp_if ();

  per_cpu_page_allocator_with_stealing_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_if),
    .rsp     (rsp_if)
  );

  logic [ADDR_W-1:0]  cfg_base;
  logic [ADDR_W-1:0]  cfg_top;
  logic [BATCH_W-1:0] cfg_batch;
  logic [HEAD_W-1:0]  list_head_q [CPUS];
  logic [HEAD_W-1:0]  link_mem [PAGES];
  bit                 on_list [PAGES];

  alloc_rsp_t  pending_results [$];
  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** per_cpu_page_allocator_with_stealing_unit: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 100)
      $display("%0t: mismatch in %s: got %h, want %h", $realtime, what, got, want);
  endtask

  function automatic void reset_model();
    cfg_base  = BASE_RESET;
    cfg_top   = TOP_RESET;
    cfg_batch = BATCH_RESET;
    for (int i = 0; i < CPUS; i++)
      list_head_q[i] = NULL_IDX;
    for (int i = 0; i < PAGES; i++)
      on_list[i] = 1'b0;
  endfunction

  function automatic logic [FP_W-1:0] first_pfn();
    logic [ADDR_W:0] sum;
    sum = {1'b0, cfg_base} + (ADDR_W+1)'(PAGE_BYTES - 1);
    return sum[ADDR_W:PAGE_SHIFT];
  endfunction

  function automatic logic [ADDR_W-1:0] page_base(logic [HEAD_W-1:0] idx);
    logic [FP_W:0] pfn;
    pfn = {1'b0, first_pfn()} + (FP_W+1)'(idx);
    return {pfn[PFN_W-1:0], {PAGE_SHIFT{1'b0}}};
  endfunction

  function automatic bit free_index(logic [ADDR_W-1:0] addr, output logic [HEAD_W-1:0] idx);
    logic [FP_W-1:0] pg;
    pg  = {1'b0, addr[ADDR_W-1:PAGE_SHIFT]} - first_pfn();
    idx = pg[HEAD_W-1:0];
    return addr[PAGE_SHIFT-1:0] == '0 && addr >= cfg_base && addr < cfg_top
           && pg < FP_W'(PAGES);
  endfunction

  function automatic void link_push(int unsigned c, logic [HEAD_W-1:0] idx);
    link_mem[idx[PG_W-1:0]] = list_head_q[c];
    list_head_q[c] = idx;
    on_list[idx[PG_W-1:0]] = 1'b1;
  endfunction

  function automatic logic [HEAD_W-1:0] link_pop(int unsigned c);
    logic [HEAD_W-1:0] idx;
    idx = list_head_q[c];
    if (idx != NULL_IDX) begin
      list_head_q[c] = link_mem[idx[PG_W-1:0]];
      on_list[idx[PG_W-1:0]] = 1'b0;
    end
    return idx;
  endfunction

  function automatic alloc_rsp_t predict_request(cmd_t cmd, logic [CPU_W-1:0] cpu,
                                                 logic [ADDR_W-1:0] addr);
    alloc_rsp_t r;
    logic [HEAD_W-1:0] idx;
    logic [BATCH_W-1:0] left;
    int unsigned c;
    c = int'(cpu) % CPUS;
    r.page_address = '0;
    if (cmd == CMD_FREE) begin
      if (free_index(addr, idx)) begin
        link_push(c, idx);
        r.status = ST_OK;
      end else begin
        r.status = ST_BAD;
      end
    end else begin
      if (list_head_q[c] == NULL_IDX) begin
        left = cfg_batch;
        for (int v = 0; v < CPUS; v++)
          if (v != c)
            while (left != 0 && list_head_q[v] != NULL_IDX) begin
              link_push(c, link_pop(v));
              left--;
            end
      end
      idx = link_pop(c);
      if (idx == NULL_IDX) begin
        r.status = ST_OOM;
      end else begin
        r.status = ST_OK;
        r.page_address = page_base(idx);
      end
    end
    return r;
  endfunction

  task automatic send_request(cmd_t cmd, logic [CPU_W-1:0] cpu, logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid   <= 1'b1;
    req_if.cmd     <= cmd;
    req_if.cpu     <= cpu;
    req_if.address <= addr;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(predict_request(cmd, cpu, addr));
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_result();
    alloc_rsp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected item", rsp_if.page_address, 32'(rsp_if.status));
      return;
    end
    want = pending_results.pop_front();
    if (rsp_if.page_address !== want.page_address)
      report_mismatch("page_address", rsp_if.page_address, want.page_address);
    if (rsp_if.status !== want.status)
      report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready)
        check_result();
      rsp_if.ready <= $urandom_range(99) >= stall_pct;
    end
  end

  task automatic check_reg(logic [REG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] want;
    want = idx == REG_BASE ? cfg_base : idx == REG_TOP ? cfg_top : DATA_W'(cfg_batch);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch("register read", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    wait_results_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE: cfg_base = value;
      REG_TOP:  cfg_top = value;
      default:  cfg_batch = value[BATCH_W-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_reg(idx);
  endtask

  task automatic test_register_reset();
    check_reg(REG_BASE);
    check_reg(REG_TOP);
    check_reg(REG_BATCH);
  endtask

  task automatic test_free_checks();
    send_request(CMD_FREE, 3'd3, cfg_base + 1);
    send_request(CMD_FREE, 3'd3, cfg_base - PAGE_BYTES);
    send_request(CMD_FREE, 3'd3, cfg_top);
    send_request(CMD_FREE, 3'd3, cfg_top - PAGE_BYTES);
    send_request(CMD_FREE, 3'd3, page_base('0));
    send_request(CMD_ALLOC, 3'd3, $urandom());
    send_request(CMD_ALLOC, 3'd3, $urandom());
  endtask

  task automatic test_stealing();
    send_request(CMD_FREE, 3'd0, page_base(HEAD_W'(1)));
    send_request(CMD_FREE, 3'd2, page_base(HEAD_W'(2)));
    send_request(CMD_FREE, 3'd7, page_base(HEAD_W'(4)));
    send_request(CMD_ALLOC, 3'd5, $urandom());
    write_reg(REG_BATCH, 32'd1);
    repeat (3) send_request(CMD_ALLOC, 3'd6, $urandom());
  endtask

  task automatic test_zero_batch();
    write_reg(REG_BATCH, 32'd0);
    send_request(CMD_FREE, 3'd1, page_base(HEAD_W'(5)));
    send_request(CMD_ALLOC, 3'd2, $urandom());
    send_request(CMD_ALLOC, 3'd1, $urandom());
  endtask

  task automatic test_double_free();
    send_request(CMD_FREE, 3'd4, page_base(HEAD_W'(6)));
    send_request(CMD_FREE, 3'd5, page_base(HEAD_W'(6)));
    send_request(CMD_ALLOC, 3'd4, $urandom());
    send_request(CMD_ALLOC, 3'd5, $urandom());
  endtask

  task automatic test_region_changes();
    write_reg(REG_BASE, 32'h0000_0000);
    write_reg(REG_TOP, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 3'd0, 32'h0000_0000);
    send_request(CMD_FREE, 3'd0, 32'(PAGES * PAGE_BYTES));
    write_reg(REG_BASE, 32'hFFFF_F000);
    write_reg(REG_TOP, 32'hFFFF_F000);
    send_request(CMD_FREE, 3'd0, 32'hFFFF_F000);
    send_request(CMD_ALLOC, 3'd0, $urandom());
    write_reg(REG_TOP, 32'h0000_0000);
    send_request(CMD_FREE, 3'd0, 32'hFFFF_F000);
  endtask

  task automatic random_request();
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] addr;
    logic [HEAD_W-1:0] idx;
    int unsigned       pick;
    int unsigned       tries;
    bit                found;
    cpu  = CPU_W'($urandom_range(CPUS - 1));
    addr = $urandom();
    pick = $urandom_range(99);
    found = 1'b0;
    if (pick < 45) begin
      send_request(CMD_ALLOC, cpu, addr);
    end else if (pick < 90) begin
      for (tries = 0; tries < 8 && !found; tries++) begin
        idx   = HEAD_W'($urandom_range($urandom_range(19) == 0 ? PAGES - 1 : 63));
        found = !on_list[idx[PG_W-1:0]];
      end
      if (found)
        send_request(CMD_FREE, cpu, page_base(idx));
      else
        send_request(CMD_ALLOC, cpu, addr);
    end else begin
      // keep the lists acyclic: never push a page that is already free
      if (free_index(addr, idx) && on_list[idx[PG_W-1:0]])
        addr[0] = 1'b1;
      send_request(CMD_FREE, cpu, addr);
    end
  endtask

  task automatic test_random_phase(logic [DATA_W-1:0] base, logic [DATA_W-1:0] top,
                                   logic [DATA_W-1:0] batch, int unsigned idle,
                                   int unsigned stall, bit hold_midway);
    write_reg(REG_BASE, base);
    write_reg(REG_TOP, top);
    write_reg(REG_BATCH, batch);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < 125; i++) begin
      if (hold_midway && i == 60)
        wait_results_drained();
      random_request();
    end
  endtask

  task automatic finish_run();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("** per_cpu_page_allocator_with_stealing_unit: PASSED **");
    else
      $display("** per_cpu_page_allocator_with_stealing_unit: FAILED **");
    $finish;
  endtask

  initial begin
    errors         = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_if.valid   <= 1'b0;
    req_if.cmd     <= CMD_ALLOC;
    req_if.cpu     <= '0;
    req_if.address <= '0;
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_reset();
    test_free_checks();
    test_stealing();
    test_zero_batch();
    test_double_free();
    test_region_changes();
    test_random_phase(32'h8000_0000, 32'h8800_0000, 32'd64, 0, 0, 1'b0);
    test_random_phase(32'h1000_0800, 32'h1800_1000, 32'd1, 66, 0, 1'b1);
    test_random_phase(32'h0000_0000, 32'hFFFF_FFFF, 32'd8191, 0, 66, 1'b0);
    test_random_phase(32'h4000_0000, 32'h4010_0000, 32'd3, 18, 18, 1'b0);
    finish_run();
  end

endmodule
